[rtl/vprm_pkg.sv]
package vprm_pkg;

    // field and result widths
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int Q_FRAC    = 14;
    localparam int Q_ONE     = 16384;

    // internal widths
    localparam int PROD_W    = 32;   // 16x16 products
    localparam int WIDE_W    = 33;   // dot and cross sums
    localparam int SQ_IN_W   = 64;   // |ref|^2 * |acc|^2
    localparam int ROOT_W    = 32;
    localparam int SQ_STAGES = 32;   // one root bit per stage
    localparam int RED_BITS  = 23;   // reduced magnitudes stay below 2^23
    localparam int RED_W     = 24;   // reduced components, signed
    localparam int SHIFT_MAX = 10;
    localparam int SQR_W     = 48;   // products of reduced components
    localparam int NUM_W     = 50;   // matrix numerators, signed
    localparam int N_W       = 48;   // squared norm
    localparam int QUO_W     = 15;   // quotient bits
    localparam int DIVD_W    = N_W + QUO_W;
    localparam int N_ENTRIES = 9;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REF_X = 2'd0,
        CFG_REF_Y = 2'd1,
        CFG_REF_Z = 2'd2
    } t_cfg_idx;

    // dot and cross product travelling alongside the root
    typedef struct packed {
        logic signed [WIDE_W-1:0] dot;
        logic signed [WIDE_W-1:0] x;
        logic signed [WIDE_W-1:0] y;
        logic signed [WIDE_W-1:0] z;
    } t_side;

    typedef logic signed [NUM_W-1:0] t_num;

endpackage

[rtl/vector_pair_to_rotation_matrix_unit.sv]
// channel  | handshake           | beat
// ---------+---------------------+-----------------------------------------------
// sample   | i_valid / o_ready   | i_accel_x, i_accel_y, i_accel_z
// matrix   | o_valid / i_ready   | o_r_0_0 .. o_r_2_2, Q1.14
// config   | i_cfg_we            | i_cfg_idx, i_cfg_data (ref_x, ref_y, ref_z)
//
// one beat in and one beat out per cycle while no finished matrix waits at the output;
// the path runs through the products, the 32-stage square root and 15-step dividers
// synchronous active-low reset empties the pipeline and loads the rest vector
// (16384, 0, 0)
// the whole pipeline holds while a finished matrix waits at the output
module vector_pair_to_rotation_matrix_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [vprm_pkg::IN_W-1:0]   i_accel_x,
    input  logic signed [vprm_pkg::IN_W-1:0]   i_accel_y,
    input  logic signed [vprm_pkg::IN_W-1:0]   i_accel_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_0_0,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_0_1,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_0_2,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_1_0,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_1_1,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_1_2,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_2_0,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_2_1,
    output logic signed [vprm_pkg::OUT_W-1:0]  o_r_2_2,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [vprm_pkg::IN_W-1:0]          i_cfg_data
);

    logic signed [vprm_pkg::IN_W-1:0] r_ref_x;
    logic signed [vprm_pkg::IN_W-1:0] r_ref_y;
    logic signed [vprm_pkg::IN_W-1:0] r_ref_z;

    logic                               w_en;
    logic                               w_p_valid;
    logic [vprm_pkg::SQ_IN_W-1:0]       w_prod;
    vprm_pkg::t_side                    w_p_side;
    logic                               w_s_valid;
    logic [vprm_pkg::ROOT_W-1:0]        w_root;
    vprm_pkg::t_side                    w_s_side;
    logic                               w_q_valid;
    vprm_pkg::t_num                     w_num [vprm_pkg::N_ENTRIES];
    logic [vprm_pkg::N_W-1:0]           w_n;
    logic [vprm_pkg::N_ENTRIES-1:0]     w_d_valid;
    logic signed [vprm_pkg::OUT_W-1:0]  w_q [vprm_pkg::N_ENTRIES];

    // rest vector registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= vprm_pkg::IN_W'(vprm_pkg::Q_ONE);
            r_ref_y <= '0;
            r_ref_z <= '0;
        end else if (i_cfg_we) begin
            case (vprm_pkg::t_cfg_idx'(i_cfg_idx))
                vprm_pkg::CFG_REF_X: r_ref_x <= i_cfg_data;
                vprm_pkg::CFG_REF_Y: r_ref_y <= i_cfg_data;
                vprm_pkg::CFG_REF_Z: r_ref_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: move whenever the output slot is free or being taken
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    vprm_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_ref_x (r_ref_x),
        .i_ref_y (r_ref_y),
        .i_ref_z (r_ref_z),
        .i_acc_x (i_accel_x),
        .i_acc_y (i_accel_y),
        .i_acc_z (i_accel_z),
        .o_valid (w_p_valid),
        .o_prod  (w_prod),
        .o_side  (w_p_side)
    );

    vprm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_val   (w_prod),
        .i_side  (w_p_side),
        .o_valid (w_s_valid),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    vprm_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .o_valid (w_q_valid),
        .o_num   (w_num),
        .o_n     (w_n)
    );

    // one divider per matrix entry
    for (genvar e = 0; e < vprm_pkg::N_ENTRIES; e++) begin : g_div
        vprm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_q_valid),
            .i_num   (w_num[e]),
            .i_n     (w_n),
            .o_valid (w_d_valid[e]),
            .o_q     (w_q[e])
        );
    end

    assign o_valid = &w_d_valid;
    assign o_r_0_0 = w_q[0];
    assign o_r_0_1 = w_q[1];
    assign o_r_0_2 = w_q[2];
    assign o_r_1_0 = w_q[3];
    assign o_r_1_1 = w_q[4];
    assign o_r_1_2 = w_q[5];
    assign o_r_2_0 = w_q[6];
    assign o_r_2_1 = w_q[7];
    assign o_r_2_2 = w_q[8];

endmodule

[rtl/vprm_products.sv]
module vprm_products (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_ref_x,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_ref_y,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_ref_z,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_acc_x,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_acc_y,
    input  logic signed [vprm_pkg::IN_W-1:0]     i_acc_z,
    output logic                                 o_valid,
    output logic        [vprm_pkg::SQ_IN_W-1:0]  o_prod,
    output vprm_pkg::t_side                      o_side
);

    localparam int PW = vprm_pkg::PROD_W;

    logic signed [PW-1:0] r_rr [3];
    logic signed [PW-1:0] r_aa [3];
    logic signed [PW-1:0] r_ra [3];
    logic signed [PW-1:0] r_cr [6];
    logic [31:0]          r_rl;
    logic [31:0]          r_al;
    vprm_pkg::t_side      r_b_side;
    logic [vprm_pkg::SQ_IN_W-1:0] r_prod;
    vprm_pkg::t_side      r_c_side;
    logic                 r_a_valid;
    logic                 r_b_valid;
    logic                 r_c_valid;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // stage a: component squares and ref-by-accel products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr[0] <= i_ref_x * i_ref_x;
            r_rr[1] <= i_ref_y * i_ref_y;
            r_rr[2] <= i_ref_z * i_ref_z;
            r_aa[0] <= i_acc_x * i_acc_x;
            r_aa[1] <= i_acc_y * i_acc_y;
            r_aa[2] <= i_acc_z * i_acc_z;
            r_ra[0] <= i_ref_x * i_acc_x;
            r_ra[1] <= i_ref_y * i_acc_y;
            r_ra[2] <= i_ref_z * i_acc_z;
            r_cr[0] <= i_ref_z * i_acc_y;
            r_cr[1] <= i_ref_y * i_acc_z;
            r_cr[2] <= i_ref_x * i_acc_z;
            r_cr[3] <= i_ref_z * i_acc_x;
            r_cr[4] <= i_ref_y * i_acc_x;
            r_cr[5] <= i_ref_x * i_acc_y;
        end
    end

    // stage b: squared lengths, dot and negated cross product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rl <= {1'b0, r_rr[0][30:0]} + {1'b0, r_rr[1][30:0]} + {1'b0, r_rr[2][30:0]};
            r_al <= {1'b0, r_aa[0][30:0]} + {1'b0, r_aa[1][30:0]} + {1'b0, r_aa[2][30:0]};
            r_b_side.dot <= {r_ra[0][PW-1], r_ra[0]} + {r_ra[1][PW-1], r_ra[1]}
                          + {r_ra[2][PW-1], r_ra[2]};
            r_b_side.x   <= {r_cr[0][PW-1], r_cr[0]} - {r_cr[1][PW-1], r_cr[1]};
            r_b_side.y   <= {r_cr[2][PW-1], r_cr[2]} - {r_cr[3][PW-1], r_cr[3]};
            r_b_side.z   <= {r_cr[4][PW-1], r_cr[4]} - {r_cr[5][PW-1], r_cr[5]};
        end
    end

    // stage c: product of squared lengths
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= 64'(r_rl) * 64'(r_al);
            r_c_side <= r_b_side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_prod  = r_prod;
    assign o_side  = r_c_side;

endmodule

[rtl/vprm_isqrt.sv]
module vprm_isqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [vprm_pkg::SQ_IN_W-1:0]        i_val,
    input  vprm_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic [vprm_pkg::ROOT_W-1:0]         o_root,
    output vprm_pkg::t_side                     o_side
);

    localparam int NS = vprm_pkg::SQ_STAGES;
    localparam int VW = vprm_pkg::SQ_IN_W;

    logic [VW-1:0]   r_v   [NS];
    logic [VW-1:0]   r_res [NS];
    vprm_pkg::t_side r_sd  [NS];
    logic            r_vld [NS];

    // one root bit per stage, remainder and partial root carried forward
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (NS - 1 - k));
        logic [VW-1:0]   v_in;
        logic [VW-1:0]   res_in;
        logic            vld_in;
        vprm_pkg::t_side sd_in;
        logic [VW:0]     trial;
        logic [VW-1:0]   n_v;
        logic [VW-1:0]   n_res;

        if (k == 0) begin : g_first
            assign v_in   = i_val;
            assign res_in = '0;
            assign vld_in = i_valid;
            assign sd_in  = i_side;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign res_in = r_res[k-1];
            assign vld_in = r_vld[k-1];
            assign sd_in  = r_sd[k-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, v_in} >= trial) begin
                n_v   = v_in - trial[VW-1:0];
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = v_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]   <= n_v;
                r_res[k] <= n_res;
                r_sd[k]  <= sd_in;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_res[NS-1][vprm_pkg::ROOT_W-1:0];
    assign o_side  = r_sd[NS-1];

endmodule

[rtl/vprm_quat.sv]
module vprm_quat (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [vprm_pkg::ROOT_W-1:0]       i_root,
    input  vprm_pkg::t_side                   i_side,
    output logic                              o_valid,
    output vprm_pkg::t_num                    o_num [vprm_pkg::N_ENTRIES],
    output logic [vprm_pkg::N_W-1:0]          o_n
);

    localparam int WW = vprm_pkg::WIDE_W;
    localparam int RW = vprm_pkg::RED_W;
    localparam int SW = vprm_pkg::SQR_W;
    localparam int NW = vprm_pkg::NUM_W;

    logic [3:0] r_vld;

    // stage 1
    logic signed [WW:0]   n_w;
    logic [WW-1:0]        n_mx;
    logic [WW-1:0]        n_my;
    logic [WW-1:0]        n_mz;
    logic [WW-1:0]        r1_mw;
    logic [WW-1:0]        r1_mx;
    logic [WW-1:0]        r1_my;
    logic [WW-1:0]        r1_mz;
    logic                 r1_sx;
    logic                 r1_sy;
    logic                 r1_sz;
    logic [WW-1:0]        r1_mor;

    // stage 2
    logic [3:0]             n_s;
    logic signed [RW-1:0]   r2_w;
    logic signed [RW-1:0]   r2_x;
    logic signed [RW-1:0]   r2_y;
    logic signed [RW-1:0]   r2_z;
    logic                   r2_zero;

    // stage 3
    logic signed [SW-1:0] r3_ww, r3_xx, r3_yy, r3_zz;
    logic signed [SW-1:0] r3_xy, r3_wz, r3_xz, r3_wy, r3_yz, r3_wx;
    logic                 r3_zero;

    // stage 4
    vprm_pkg::t_num       r4_num [vprm_pkg::N_ENTRIES];
    logic [vprm_pkg::N_W-1:0] r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // stage 1: scalar part and magnitudes, or of magnitudes marks the top bit
    always_comb begin
        n_w  = {2'b00, i_root} + {i_side.dot[WW-1], i_side.dot};
        n_mx = i_side.x[WW-1] ? WW'(-i_side.x) : WW'(i_side.x);
        n_my = i_side.y[WW-1] ? WW'(-i_side.y) : WW'(i_side.y);
        n_mz = i_side.z[WW-1] ? WW'(-i_side.z) : WW'(i_side.z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mw  <= n_w[WW-1:0];
            r1_mx  <= n_mx;
            r1_my  <= n_my;
            r1_mz  <= n_mz;
            r1_sx  <= i_side.x[WW-1];
            r1_sy  <= i_side.y[WW-1];
            r1_sz  <= i_side.z[WW-1];
            r1_mor <= n_w[WW-1:0] | n_mx | n_my | n_mz;
        end
    end

    // stage 2: shift so the largest magnitude drops below 2^23
    always_comb begin
        n_s = '0;
        for (int k = 1; k <= vprm_pkg::SHIFT_MAX; k++) begin
            if (r1_mor[vprm_pkg::RED_BITS - 1 + k]) begin
                n_s = 4'(k);
            end
        end
    end

    function automatic logic signed [RW-1:0] red(input logic [WW-1:0] m, input logic neg,
                                                 input logic [3:0] s);
        logic [RW-1:0] v;
        begin
            v = RW'(m >> s);
            red = neg ? -$signed(v) : $signed(v);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_w    <= red(r1_mw, 1'b0, n_s);
            r2_x    <= red(r1_mx, r1_sx, n_s);
            r2_y    <= red(r1_my, r1_sy, n_s);
            r2_z    <= red(r1_mz, r1_sz, n_s);
            r2_zero <= (r1_mor == '0);
        end
    end

    // stage 3: second-order products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ww   <= r2_w * r2_w;
            r3_xx   <= r2_x * r2_x;
            r3_yy   <= r2_y * r2_y;
            r3_zz   <= r2_z * r2_z;
            r3_xy   <= r2_x * r2_y;
            r3_wz   <= r2_w * r2_z;
            r3_xz   <= r2_x * r2_z;
            r3_wy   <= r2_w * r2_y;
            r3_yz   <= r2_y * r2_z;
            r3_wx   <= r2_w * r2_x;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: numerators and norm, identity over n of one for a zero quaternion
    function automatic vprm_pkg::t_num sx(input logic signed [SW-1:0] a);
        sx = {{(NW-SW){a[SW-1]}}, a};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r3_zero) begin
                for (int e = 0; e < vprm_pkg::N_ENTRIES; e++) begin
                    r4_num[e] <= '0;
                end
                r4_num[0] <= NW'(1);
                r4_num[4] <= NW'(1);
                r4_num[8] <= NW'(1);
                r4_n      <= vprm_pkg::N_W'(1);
            end else begin
                r4_num[0] <= sx(r3_ww) + sx(r3_xx) - sx(r3_yy) - sx(r3_zz);
                r4_num[1] <= (sx(r3_xy) - sx(r3_wz)) <<< 1;
                r4_num[2] <= (sx(r3_xz) + sx(r3_wy)) <<< 1;
                r4_num[3] <= (sx(r3_xy) + sx(r3_wz)) <<< 1;
                r4_num[4] <= sx(r3_ww) - sx(r3_xx) + sx(r3_yy) - sx(r3_zz);
                r4_num[5] <= (sx(r3_yz) - sx(r3_wx)) <<< 1;
                r4_num[6] <= (sx(r3_xz) - sx(r3_wy)) <<< 1;
                r4_num[7] <= (sx(r3_yz) + sx(r3_wx)) <<< 1;
                r4_num[8] <= sx(r3_ww) - sx(r3_xx) - sx(r3_yy) + sx(r3_zz);
                r4_n      <= r3_ww[vprm_pkg::N_W-1:0] + r3_xx[vprm_pkg::N_W-1:0]
                           + r3_yy[vprm_pkg::N_W-1:0] + r3_zz[vprm_pkg::N_W-1:0];
            end
        end
    end

    assign o_valid = r_vld[3];
    assign o_num   = r4_num;
    assign o_n     = r4_n;

endmodule

[rtl/vprm_div.sv]
module vprm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  vprm_pkg::t_num                    i_num,
    input  logic [vprm_pkg::N_W-1:0]          i_n,
    output logic                              o_valid,
    output logic signed [vprm_pkg::OUT_W-1:0] o_q
);

    localparam int NW = vprm_pkg::N_W;
    localparam int QW = vprm_pkg::QUO_W;
    localparam int DW = vprm_pkg::DIVD_W;

    logic [NW-1:0]   n_mag;
    logic [DW-1:0]   n_divd;

    logic            r0_vld;
    logic            r0_neg;
    logic [NW-1:0]   r0_rem;
    logic [QW-1:0]   r0_low;
    logic [NW-1:0]   r0_n;

    logic            r_vld [QW];
    logic            r_neg [QW];
    logic [NW-1:0]   r_rem [QW];
    logic [QW-1:0]   r_low [QW];
    logic [QW-1:0]   r_q   [QW];
    logic [NW-1:0]   r_n   [QW];

    logic            r_out_vld;
    logic signed [vprm_pkg::OUT_W-1:0] r_out;
    logic [QW-1:0]   n_sat;

    // scaled magnitude plus half the divisor for rounding
    always_comb begin
        n_mag  = i_num[vprm_pkg::NUM_W-1] ? NW'(-i_num) : NW'(i_num);
        n_divd = {n_mag, vprm_pkg::Q_FRAC'(0)} + DW'(i_n >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg <= i_num[vprm_pkg::NUM_W-1];
            r0_rem <= n_divd[DW-1:QW];
            r0_low <= n_divd[QW-1:0];
            r0_n   <= i_n;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          vld_in;
        logic          neg_in;
        logic [NW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [NW-1:0] n_in;
        logic [NW:0]   trial;
        logic          take;

        if (k == 0) begin : g_first
            assign vld_in = r0_vld;
            assign neg_in = r0_neg;
            assign rem_in = r0_rem;
            assign low_in = r0_low;
            assign q_in   = '0;
            assign n_in   = r0_n;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign neg_in = r_neg[k-1];
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign n_in   = r_n[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign take  = (trial >= {1'b0, n_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= neg_in;
                r_rem[k] <= take ? NW'(trial - {1'b0, n_in}) : trial[NW-1:0];
                r_low[k] <= low_in << 1;
                r_q[k]   <= {q_in[QW-2:0], take};
                r_n[k]   <= n_in;
            end
        end
    end

    // saturate to one and restore the sign
    assign n_sat = (r_q[QW-1] > QW'(vprm_pkg::Q_ONE)) ? QW'(vprm_pkg::Q_ONE) : r_q[QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_neg[QW-1] ? -$signed({1'b0, n_sat}) : $signed({1'b0, n_sat});
        end
    end

    assign o_valid = r_out_vld;
    assign o_q     = r_out;

endmodule
